@@ rtl/stereo_peak_limiter_gate_unit_assert.svh @@
// Assertion macros shared by the RTL.
// Each expects clk and rst_n in scope.
`ifndef STEREO_PEAK_LIMITER_GATE_UNIT_ASSERT_SVH
`define STEREO_PEAK_LIMITER_GATE_UNIT_ASSERT_SVH

// Expression holds at every edge out of reset.
`define SPLG_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define SPLG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/splg_pkg.sv @@
`timescale 1ns / 1ps
package splg_pkg;

    localparam int SMP_W   = 24;
    localparam int LVL_W   = 23;
    localparam int CQ_W    = 17;
    localparam int GQ_W    = 16;

    // bit-serial multiplier: signed A, unsigned B, one B bit per cycle
    localparam int MUL_AW  = 34;
    localparam int MUL_BW  = 17;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int MUL_CW  = $clog2(MUL_BW);

    // restoring divider: quotient below 2^16 since numerator < denominator
    localparam int DIV_W   = 23;
    localparam int DIV_QW  = 16;
    localparam int DIV_CW  = $clog2(DIV_QW);

    localparam logic [CQ_W-1:0]  ONE_Q16  = 17'd65536;
    localparam logic [CQ_W-1:0]  HYST_Q16 = 17'd2621;
    localparam logic [LVL_W-1:0] SAT_POS  = 23'h7FFFFF;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_PREAMP    = 3'd2,
        REG_MAKEUP    = 3'd3,
        REG_WET       = 3'd4,
        REG_ATTACK    = 3'd5,
        REG_RELEASE   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic [MUL_BW-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MUL_PW-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
    } div_rsp_t;

    function automatic logic [CQ_W-1:0] clamp_one(input logic [CQ_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ rtl/splg_in_if.sv @@
`timescale 1ns / 1ps
interface splg_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

@@ rtl/splg_out_if.sv @@
`timescale 1ns / 1ps
interface splg_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/stereo_peak_limiter_gate_unit.sv @@
// Linked stereo peak limiter / noise gate. One stereo frame per input beat, one
// processed frame per output beat. Frames are handled one at a time: each frame
// runs through the shared bit-serial multiplier for 18 products (each: issue,
// 17 multiplier bits, hand-back) plus three further steps (target, rate select,
// output load). In limiter mode with the level above threshold a restoring
// divide is added (issue, 16 quotient bits, hand-back). The next frame can be
// accepted in the cycle after the result is loaded. A finished frame waits in
// the output register while the next frame is accepted and worked on; it only
// holds the block up if it is still unclaimed when the following result is
// ready.
// Configuration writes take effect at once and must only be made while idle.
`timescale 1ns / 1ps
`include "stereo_peak_limiter_gate_unit_assert.svh"
module stereo_peak_limiter_gate_unit
#(
    parameter int LEVEL_ATTACK_COEF  = 65536,
    parameter int LEVEL_RELEASE_COEF = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    splg_in_if.sink     in_frame,
    splg_out_if.source  out_frame,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [22:0] cfg_data
);
    import splg_pkg::*;

    // level detector coefficients, clamped to one
    localparam logic [CQ_W-1:0] LAC = (LEVEL_ATTACK_COEF > 65536) ? ONE_Q16
                                      : CQ_W'(LEVEL_ATTACK_COEF);
    localparam logic [CQ_W-1:0] LRC = (LEVEL_RELEASE_COEF > 65536) ? ONE_Q16
                                      : CQ_W'(LEVEL_RELEASE_COEF);
    localparam logic [CQ_W-1:0] LRC_INV = ONE_Q16 - LRC;

    typedef enum logic [3:0] {
        S_IDLE, S_RECT, S_LVL, S_TGT, S_DIV, S_KSEL,
        S_GAIN_A, S_GAIN_B, S_WET1, S_WET2, S_WET3, S_WET4, S_DRY, S_OUT
    } state_t;

    // configuration
    logic             mode_reg;
    logic [LVL_W-1:0] thr_reg;
    logic [GQ_W-1:0]  preamp_reg, makeup_reg;
    logic [CQ_W-1:0]  wet_reg, att_reg, rel_reg;

    // sequencer and channel state
    state_t            state_reg, state_next;
    logic              ch_reg, ch_next;
    logic              issued_reg, issued_next;
    logic [LVL_W-1:0]  peak_reg [2];
    logic [LVL_W-1:0]  peak_next [2];
    logic [CQ_W-1:0]   gain_reg [2];
    logic [CQ_W-1:0]   gain_next [2];
    logic [CQ_W-1:0]   prior_reg, prior_next;
    logic [CQ_W-1:0]   target_reg, target_next;
    logic [CQ_W-1:0]   k_reg, k_next;
    logic              out_valid_reg, out_valid_next;

    // per-frame working registers
    logic signed [SMP_W-1:0] x_reg [2];
    logic signed [SMP_W-1:0] x_next [2];
    logic [LVL_W-1:0]        rect_reg, rect_next;
    logic [33:0]             gsum_reg, gsum_next;
    logic signed [33:0]      w_reg, w_next;
    logic [SMP_W-1:0]        res_reg [2];
    logic [SMP_W-1:0]        res_next [2];
    logic [SMP_W-1:0]        outl_reg, outl_next, outr_reg, outr_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // operand views
    logic signed [SMP_W-1:0] x_cur;
    logic [SMP_W-1:0]        mag;
    logic [LVL_W-1:0]        peak_cur, lv;
    logic                    up;
    logic [CQ_W-1:0]         wm, att, rel;
    logic                    mul_state;

    assign x_cur    = x_reg[ch_reg];
    assign mag      = x_cur[SMP_W-1] ? SMP_W'(~x_cur + 1'b1) : x_cur;
    assign peak_cur = peak_reg[ch_reg];
    assign up       = rect_reg > peak_cur;
    assign lv       = (peak_reg[0] > peak_reg[1]) ? peak_reg[0] : peak_reg[1];
    assign wm       = clamp_one(wet_reg);
    assign att      = clamp_one(att_reg);
    assign rel      = clamp_one(rel_reg);

    assign mul_state = (state_reg == S_RECT)   || (state_reg == S_LVL)
                    || (state_reg == S_GAIN_A) || (state_reg == S_GAIN_B)
                    || (state_reg == S_WET1)   || (state_reg == S_WET2)
                    || (state_reg == S_WET3)   || (state_reg == S_WET4)
                    || (state_reg == S_DRY);

    // one operation in flight at a time; issue once per state
    assign mul_req.start = mul_state && !issued_reg;
    assign div_req.start = (state_reg == S_DIV) && !issued_reg;
    assign div_req.num   = thr_reg;
    assign div_req.den   = lv;

    // multiplier operand selection
    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (state_reg)
            S_RECT:
            begin
                mul_req.a = {10'b0, mag};
                mul_req.b = {1'b0, preamp_reg};
            end
            S_LVL:
            begin
                mul_req.a = up ? {11'b0, LVL_W'(rect_reg - peak_cur)} : {11'b0, peak_cur};
                mul_req.b = up ? LAC : LRC_INV;
            end
            S_GAIN_A:
            begin
                mul_req.a = {17'b0, gain_reg[ch_reg]};
                mul_req.b = ONE_Q16 - k_reg;
            end
            S_GAIN_B:
            begin
                mul_req.a = {17'b0, target_reg};
                mul_req.b = k_reg;
            end
            S_WET1:
            begin
                mul_req.a = {{10{x_cur[SMP_W-1]}}, x_cur};
                mul_req.b = gain_reg[ch_reg];
            end
            S_WET2:
            begin
                mul_req.a = w_reg;
                mul_req.b = {1'b0, makeup_reg};
            end
            S_WET3:
            begin
                mul_req.a = w_reg;
                mul_req.b = {1'b0, preamp_reg};
            end
            S_WET4:
            begin
                mul_req.a = w_reg;
                mul_req.b = wm;
            end
            S_DRY:
            begin
                mul_req.a = {{10{x_cur[SMP_W-1]}}, x_cur};
                mul_req.b = ONE_Q16 - wm;
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    splg_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    splg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        logic signed [CQ_W:0]  d;
        logic [CQ_W:0]         ksum;
        logic [33:0]           gtot;
        logic signed [34:0]    tot;
        logic signed [24:0]    dry;

        state_next     = state_reg;
        ch_next        = ch_reg;
        issued_next    = issued_reg;
        peak_next      = peak_reg;
        gain_next      = gain_reg;
        prior_next     = prior_reg;
        target_next    = target_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        rect_next      = rect_reg;
        gsum_next      = gsum_reg;
        w_next         = w_reg;
        res_next       = res_reg;
        outl_next      = outl_reg;
        outr_next      = outr_reg;

        d    = $signed({1'b0, prior_reg}) - $signed({1'b0, target_reg});
        ksum = ({1'b0, att} + {1'b0, rel}) >> 1;
        gtot = gsum_reg + mul_rsp.p[33:0];
        dry  = mul_rsp.p[40:16];
        tot  = {w_reg[33], w_reg} + {{10{dry[24]}}, dry};

        if (mul_req.start || div_req.start)
        begin
            issued_next = 1'b1;
        end
        if (mul_rsp.done || div_rsp.done)
        begin
            issued_next = 1'b0;
        end

        if (out_valid_reg && out_frame.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_frame.valid)
                begin
                    x_next[0]  = in_frame.left_in;
                    x_next[1]  = in_frame.right_in;
                    ch_next    = 1'b0;
                    state_next = S_RECT;
                end
            end
            S_RECT:
            begin
                if (mul_rsp.done)
                begin
                    // saturate |x|*preamp >> 12 into 23 bits
                    rect_next  = (mul_rsp.p[50:35] != '0) ? SAT_POS : mul_rsp.p[34:12];
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                if (mul_rsp.done)
                begin
                    peak_next[ch_reg] = up ? LVL_W'(peak_cur + mul_rsp.p[38:16])
                                           : mul_rsp.p[38:16];
                    if (!ch_reg)
                    begin
                        ch_next    = 1'b1;
                        state_next = S_RECT;
                    end
                    else
                    begin
                        state_next = S_TGT;
                    end
                end
            end
            S_TGT:
            begin
                if (mode_reg && (lv > thr_reg))
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    target_next = (!mode_reg && (lv < thr_reg)) ? '0 : ONE_Q16;
                    state_next  = S_KSEL;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    target_next = {1'b0, div_rsp.quo};
                    state_next  = S_KSEL;
                end
            end
            S_KSEL:
            begin
                // hysteresis on the target step picks the smoothing rate
                priority if (d > $signed({1'b0, HYST_Q16}))
                    k_next = att;
                else if (d < -$signed({1'b0, HYST_Q16}))
                    k_next = rel;
                else
                    k_next = ksum[CQ_W-1:0];
                prior_next = target_reg;
                ch_next    = 1'b0;
                state_next = S_GAIN_A;
            end
            S_GAIN_A:
            begin
                if (mul_rsp.done)
                begin
                    gsum_next  = mul_rsp.p[33:0];
                    state_next = S_GAIN_B;
                end
            end
            S_GAIN_B:
            begin
                if (mul_rsp.done)
                begin
                    gain_next[ch_reg] = gtot[32:16];
                    state_next        = S_WET1;
                end
            end
            S_WET1:
            begin
                if (mul_rsp.done)
                begin
                    w_next     = mul_rsp.p[49:16];
                    state_next = S_WET2;
                end
            end
            S_WET2:
            begin
                if (mul_rsp.done)
                begin
                    w_next     = mul_rsp.p[45:12];
                    state_next = S_WET3;
                end
            end
            S_WET3:
            begin
                if (mul_rsp.done)
                begin
                    w_next     = mul_rsp.p[45:12];
                    state_next = S_WET4;
                end
            end
            S_WET4:
            begin
                if (mul_rsp.done)
                begin
                    w_next     = mul_rsp.p[49:16];
                    state_next = S_DRY;
                end
            end
            S_DRY:
            begin
                if (mul_rsp.done)
                begin
                    priority if (tot > 35'sd8388607)
                        res_next[ch_reg] = 24'h7FFFFF;
                    else if (tot < -35'sd8388608)
                        res_next[ch_reg] = 24'h800000;
                    else
                        res_next[ch_reg] = tot[SMP_W-1:0];
                    if (!ch_reg)
                    begin
                        ch_next    = 1'b1;
                        state_next = S_GAIN_A;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // wait only if the previous result is still held
                if (!out_valid_reg || out_frame.ready)
                begin
                    outl_next      = res_reg[0];
                    outr_next      = res_reg[1];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            issued_reg    <= 1'b0;
            peak_reg[0]   <= '0;
            peak_reg[1]   <= '0;
            gain_reg[0]   <= ONE_Q16;
            gain_reg[1]   <= ONE_Q16;
            prior_reg     <= ONE_Q16;
            target_reg    <= ONE_Q16;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            outl_reg      <= '0;
            outr_reg      <= '0;
            mode_reg      <= 1'b1;
            thr_reg       <= 23'd4194304;
            preamp_reg    <= 16'd4096;
            makeup_reg    <= 16'd4096;
            wet_reg       <= ONE_Q16;
            att_reg       <= ONE_Q16;
            rel_reg       <= 17'd14;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            issued_reg    <= issued_next;
            peak_reg      <= peak_next;
            gain_reg      <= gain_next;
            prior_reg     <= prior_next;
            target_reg    <= target_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            outl_reg      <= outl_next;
            outr_reg      <= outr_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_MODE:      mode_reg   <= cfg_data[0];
                    REG_THRESHOLD: thr_reg    <= cfg_data;
                    REG_PREAMP:    preamp_reg <= cfg_data[15:0];
                    REG_MAKEUP:    makeup_reg <= cfg_data[15:0];
                    REG_WET:       wet_reg    <= cfg_data[16:0];
                    REG_ATTACK:    att_reg    <= cfg_data[16:0];
                    REG_RELEASE:   rel_reg    <= cfg_data[16:0];
                    default:       mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // datapath holding registers, no reset
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rect_reg <= rect_next;
        gsum_reg <= gsum_next;
        w_reg    <= w_next;
        res_reg  <= res_next;
    end

    assign in_frame.ready      = (state_reg == S_IDLE);
    assign out_frame.valid     = out_valid_reg;
    assign out_frame.left_out  = outl_reg;
    assign out_frame.right_out = outr_reg;

    `SPLG_ASSERT_HOLDS(a_target_range, target_reg <= ONE_Q16, "target gain above one")
    `SPLG_ASSERT_HOLDS(a_gain_range,
        (gain_reg[0] <= ONE_Q16) && (gain_reg[1] <= ONE_Q16), "smoothed gain above one")
    `SPLG_ASSERT_HOLDS(a_single_op, !(mul_req.start && div_req.start), "mul and div together")
    `SPLG_ASSERT_NEXT(a_accept_starts, in_frame.valid && in_frame.ready,
        (state_reg == S_RECT) && !ch_reg, "accepted beat did not start left channel")

endmodule

@@ rtl/splg_mul.sv @@
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle.
module splg_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  splg_pkg::mul_req_t req,
    output splg_pkg::mul_rsp_t rsp
);
    import splg_pkg::*;

    logic signed [MUL_PW-1:0] acc_reg, acc_next;
    logic signed [MUL_PW-1:0] mcand_reg, mcand_next;
    logic [MUL_BW-1:0]        mplier_reg, mplier_next;
    logic [MUL_CW-1:0]        cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = {{(MUL_PW-MUL_AW){req.a[MUL_AW-1]}}, req.a};
            mplier_next = req.b;
            cnt_next    = MUL_CW'(MUL_BW - 1);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

@@ rtl/splg_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Expects num < den.
module splg_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  splg_pkg::div_req_t req,
    output splg_pkg::div_rsp_t rsp
);
    import splg_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [DIV_QW-1:0] quo_reg, quo_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, 1'b0};
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = DIV_CW'(DIV_QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ verif/tb_stereo_peak_limiter_gate_unit.sv @@
`timescale 1ns / 1ps
module tb_stereo_peak_limiter_gate_unit;
    import splg_pkg::*;

    // Level detector coefficients, as the block is built here (defaults)
    localparam longint LVL_ATT = 65536;
    localparam longint LVL_REL = 14;
    localparam longint ONE     = 65536;
    localparam longint HYST    = 2621;
    // index with no register behind it: writes must be ignored
    localparam logic [2:0] REG_NONE = 3'd7;
    // cycles without any beat before the run is declared hung;
    // it covers one frame, the longest sender gap and short receiver stalls
    localparam int HANG_LIMIT = 8000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [22:0] cfg_data;

    splg_in_if  in_frame ();
    splg_out_if out_frame ();

    stereo_peak_limiter_gate_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_frame  (in_frame),
        .out_frame (out_frame),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the register file
    longint m_mode, m_thr, m_pre, m_mku, m_wet, m_att, m_rel;
    // Shadow copy of the detector / gain state
    longint m_level [2];
    longint m_prev_target;
    longint m_gain  [2];

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } frame_t;

    frame_t expected_frames [$];

    int errors;
    int frames_sent;
    int frames_checked;
    int cfg_writes;
    int idle_cycles;
    int burst_left;
    int stall_style;
    int gap_max;

    function automatic longint clamp_unity(longint v);
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic logic signed [23:0] sat24(longint v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    task automatic shadow_reset();
        m_mode = 1;
        m_thr  = 4194304;
        m_pre  = 4096;
        m_mku  = 4096;
        m_wet  = 65536;
        m_att  = 65536;
        m_rel  = 14;
        m_level[0] = 0;
        m_level[1] = 0;
        m_prev_target = ONE;
        m_gain[0] = ONE;
        m_gain[1] = ONE;
    endtask

    // Works out the processed frame and moves the shadow state on by one frame
    function automatic frame_t limit_frame(logic signed [23:0] l, logic signed [23:0] r);
        longint x [2];
        longint mag, rect, lv, tgt, k, att, rel, wm, d, g, w, dry;
        frame_t f;
        x[0] = l;
        x[1] = r;
        for (int ch = 0; ch < 2; ch++)
        begin
            mag  = (x[ch] < 0) ? -x[ch] : x[ch];
            rect = (mag * m_pre) >> 12;
            if (rect > 8388607)
                rect = 8388607;
            if (rect > m_level[ch])
                m_level[ch] = m_level[ch] + (((rect - m_level[ch]) * LVL_ATT) >> 16);
            else
                m_level[ch] = (m_level[ch] * (ONE - LVL_REL)) >> 16;
            m_level[ch] = m_level[ch] & 64'h7FFFFF;
        end
        lv = (m_level[0] > m_level[1]) ? m_level[0] : m_level[1];
        if (m_mode != 0)
            tgt = (lv > m_thr) ? ((m_thr << 16) / lv) : ONE;
        else
            tgt = (lv < m_thr) ? 0 : ONE;
        att = clamp_unity(m_att);
        rel = clamp_unity(m_rel);
        d = m_prev_target - tgt;
        if (d > HYST)
            k = att;
        else if (d < -HYST)
            k = rel;
        else
            k = (att + rel) >> 1;
        wm = clamp_unity(m_wet);
        for (int ch = 0; ch < 2; ch++)
        begin
            g = ((ONE - k) * m_gain[ch] + k * tgt) >> 16;
            m_gain[ch] = g;
            // arithmetic shifts of signed values floor, as required
            w   = (x[ch] * g) >>> 16;
            w   = (w * m_mku) >>> 12;
            w   = (w * m_pre) >>> 12;
            w   = (w * wm) >>> 16;
            dry = (x[ch] * (ONE - wm)) >>> 16;
            if (ch == 0)
                f.left = sat24(w + dry);
            else
                f.right = sat24(w + dry);
        end
        m_prev_target = tgt;
        return f;
    endfunction

    // Register write, one cycle of cfg_we; shadow follows with the same masking
    task automatic cfg_write(logic [2:0] idx, logic [22:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:      m_mode = data & 23'h1;
            REG_THRESHOLD: m_thr  = data & 23'h7FFFFF;
            REG_PREAMP:    m_pre  = data & 23'hFFFF;
            REG_MAKEUP:    m_mku  = data & 23'hFFFF;
            REG_WET:       m_wet  = data & 23'h1FFFF;
            REG_ATTACK:    m_att  = data & 23'h1FFFF;
            REG_RELEASE:   m_rel  = data & 23'h1FFFF;
            default:       ;
        endcase
        cfg_writes++;
    endtask

    task automatic cfg_all(longint md, longint thr, longint pre, longint mku,
                           longint wet, longint att, longint rel);
        cfg_write(REG_MODE, 23'(md));
        cfg_write(REG_THRESHOLD, 23'(thr));
        cfg_write(REG_PREAMP, 23'(pre));
        cfg_write(REG_MAKEUP, 23'(mku));
        cfg_write(REG_WET, 23'(wet));
        cfg_write(REG_ATTACK, 23'(att));
        cfg_write(REG_RELEASE, 23'(rel));
    endtask

    // One input beat. Called at a rising edge; returns at one.
    task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
        in_frame.valid    <= 1'b1;
        in_frame.left_in  <= l;
        in_frame.right_in <= r;
        @(posedge clk);
        while (!in_frame.ready)
            @(posedge clk);
        expected_frames.push_back(limit_frame(l, r));
        frames_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // gap with valid low, so valid never drops and rises in one step
            in_frame.valid <= 1'b0;
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Block idle: all results back, sender quiet
    task automatic drain();
        in_frame.valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sample mix: full scale, small signals, silence, near the rails
    function automatic logic signed [23:0] pick_sample(int scale);
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0:       v = 24'h800000;
            1:       v = 24'h7FFFFF;
            2:       v = 24'h000000;
            default:
            begin
                v = 24'($urandom);
                if (scale < 23)
                    v = $signed(v) >>> (23 - scale);
            end
        endcase
        return v;
    endfunction

    // Checker: compares every output beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_frame.valid && out_frame.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("output beat with nothing expected: %0d %0d",
                       out_frame.left_out, out_frame.right_out);
                errors++;
            end
            else
            begin
                frame_t e;
                e = expected_frames.pop_front();
                if (out_frame.left_out !== e.left)
                begin
                    $error("left_out expected %0d actual %0d", e.left, out_frame.left_out);
                    errors++;
                end
                if (out_frame.right_out !== e.right)
                begin
                    $error("right_out expected %0d actual %0d", e.right, out_frame.right_out);
                    errors++;
                end
                frames_checked++;
            end
        end
    end

    // Receiver back-pressure; style changes per phase
    always @(posedge clk)
    begin
        case (stall_style)
            0:       out_frame.ready <= 1'b1;
            1:       out_frame.ready <= ($urandom_range(0, 2) != 0);
            2:       out_frame.ready <= (($urandom_range(0, 15)) > 11);
            default: out_frame.ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Hang detector: any beat on either side clears it
    always @(posedge clk)
    begin
        if ((in_frame.valid && in_frame.ready) || (out_frame.valid && out_frame.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > HANG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", HANG_LIMIT);
            $display("tb_stereo_peak_limiter_gate_unit: done, errors");
            $finish;
        end
    end

    // Directed: rails, silence, both laws, extreme settings, clamped coefficients
    task automatic test_directed();
        stall_style = 0;
        send_frame(24'sh7FFFFF, 24'sh800000);
        send_frame(24'sh800000, 24'sh7FFFFF);
        send_frame(24'sh000000, 24'sh000000);
        send_frame(24'sh000001, -24'sh000001);
        drain();
        // gate law, threshold zero: level never below, gain stays open
        cfg_all(0, 0, 65535, 65535, 0, 0, 0);
        send_frame(24'sh7FFFFF, 24'sh000000);
        send_frame(24'sh000000, 24'sh800000);
        send_frame(24'sh123456, -24'sh123456);
        drain();
        // gate law, top threshold: gate shuts; coefficients above one clamp
        cfg_all(0, 23'h7FFFFF, 0, 0, 131071, 131071, 131071);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        send_frame(24'sh400000, 24'sh000000);
        send_frame(24'sh000000, 24'sh000000);
        drain();
        // limiter, threshold zero: level above zero divides to zero gain
        cfg_all(1, 0, 4096, 4096, 65536, 65536, 65536);
        send_frame(24'sh000000, 24'sh000000);
        send_frame(24'sh000001, 24'sh000000);
        send_frame(24'sh7FFFFF, 24'sh800000);
        drain();
        // limiter, hot preamp, slow release, half wet
        cfg_all(1, 23'h100000, 65535, 8192, 32768, 65536, 14);
        send_frame(24'sh7FFFFF, 24'sh010000);
        send_frame(24'sh001000, 24'sh800000);
        send_frame(24'sh000000, 24'sh000000);
        send_frame(24'sh000100, -24'sh000100);
        drain();
        // unknown index ignored; wide value keeps only the low bits
        cfg_write(REG_NONE, 23'h7FFFFF);
        cfg_write(REG_MODE, 23'h7FFFFE);
        cfg_write(REG_WET, 23'h7E0000);
        cfg_write(REG_PREAMP, 23'h7F1000);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        send_frame(24'sh000010, 24'sh000000);
        drain();
    endtask

    // Random phases: one setting each, then envelope-shaped programme material
    task automatic test_random_phase(int n_frames);
        longint thr, pre, att, rel, wet;
        int scale, seg;
        case ($urandom_range(0, 3))
            0:       thr = 0;
            1:       thr = 23'h7FFFFF;
            default: thr = $urandom_range(0, 23'h7FFFFF);
        endcase
        pre = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(2048, 8192);
        att = ($urandom_range(0, 3) == 0) ? $urandom_range(65536, 131071) : $urandom_range(0, 65536);
        rel = ($urandom_range(0, 3) == 0) ? $urandom_range(65536, 131071) : $urandom_range(0, 4096);
        wet = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : 65536;
        cfg_all($urandom_range(0, 1), thr, pre, $urandom_range(0, 65535), wet, att, rel);
        stall_style = $urandom_range(0, 3);
        gap_max = ($urandom_range(0, 1) == 1) ? 600 : 40;
        seg = 0;
        scale = 23;
        for (int i = 0; i < n_frames; i++)
        begin
            // loud and quiet passages so the detector rises and decays
            if (seg == 0)
            begin
                seg = $urandom_range(4, 40);
                scale = $urandom_range(0, 23);
            end
            seg--;
            send_frame(pick_sample(scale), pick_sample(scale));
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        frames_sent = 0;
        frames_checked = 0;
        cfg_writes = 0;
        idle_cycles = 0;
        burst_left = 4;
        stall_style = 0;
        gap_max = 40;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_MODE;
        cfg_data = '0;
        in_frame.valid = 1'b0;
        in_frame.left_in = '0;
        in_frame.right_in = '0;
        out_frame.ready = 1'b1;
        shadow_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        for (int p = 0; p < 8; p++)
            test_random_phase(228);

        in_frame.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("covered %0d frames, %0d checked, %0d register writes",
                 frames_sent, frames_checked, cfg_writes);
        $display("both laws, extreme thresholds and gains, clamped coefficients, back-pressure");
        if (errors == 0 && expected_frames.size() == 0)
            $display("tb_stereo_peak_limiter_gate_unit: done, clean");
        else
            $display("tb_stereo_peak_limiter_gate_unit: done, errors");
        $finish;
    end
endmodule
